// ===== rtl/sktr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktr_pkg
// types, constants and lookup tables shared by the key transliterator
// ----------------------------------------------------------------------------
package sktr_pkg;

	localparam int NCONS = 42;
	localparam int NVOW  = 10;

	typedef logic [7:0]  lsb_t;
	typedef logic [15:0] cp_t;

	// one keystroke
	typedef struct packed {
		cp_t  prev_char;
		logic has_context;
		logic toggle_key;
		logic key_is_plain;
		cp_t  key_char;
	} key_t;

	// decoded result of one keystroke, cnt = number of characters (0..3)
	typedef struct packed {
		logic            handled;
		logic            delete_previous;
		logic [1:0]      cnt;
		logic [2:0][15:0] ch;
	} res_t;

	localparam cp_t CP_HAL  = 16'h0dca;
	localparam cp_t CP_ZWJ  = 16'h200d;
	localparam cp_t CP_ZWNJ = 16'h200c;
	localparam cp_t CP_RA   = 16'h0dbb;
	localparam cp_t CP_YA   = 16'h0dba;
	localparam cp_t CP_JOINER_BASE = 16'h2000;
	localparam cp_t CP_SINH_PAGE   = 16'h0d00;
	localparam logic [8:0] SINH_BLOCK_HI = 9'h01b;

	localparam lsb_t LSB_ZWNJ    = 8'h0c;
	localparam lsb_t LSB_ZWJ     = 8'h0d;
	localparam lsb_t LSB_CONS_LO = 8'h9a;
	localparam lsb_t LSB_CONS_HI = 8'hc6;

	localparam cp_t KEY_LC_W = 16'h0077;
	localparam cp_t KEY_UC_W = 16'h0057;
	localparam cp_t KEY_UC_H = 16'h0048;
	localparam cp_t KEY_UC_G = 16'h0047;
	localparam cp_t KEY_UC_R = 16'h0052;
	localparam cp_t KEY_UC_Y = 16'h0059;

	localparam lsb_t CONS_CHR [NCONS] = '{
		8'ha4, 8'ha5, 8'hc0, 8'h0c, 8'hbb, 8'hbb, 8'had, 8'ha7, 8'hba, 8'hba,
		8'hb4, 8'hb5, 8'hc3, 8'hc1, 8'haf, 8'ha9, 8'hc6, 8'hc6, 8'h9c, 8'h9f,
		8'hc4, 8'hc4, 8'ha2, 8'ha3, 8'h9a, 8'h9b, 8'hbd, 8'hc5, 8'h8f, 8'h90,
		8'h82, 8'h9e, 8'ha0, 8'ha1, 8'hc0, 8'hc0, 8'hb6, 8'hb7, 8'hb1, 8'hab,
		8'hb8, 8'hb9};
	localparam lsb_t CONS_MP [NCONS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hae, 8'ha8, 8'h00, 8'h00,
		8'hb5, 8'hb5, 8'hc2, 8'hc2, 8'hb0, 8'haa, 8'h00, 8'h00, 8'h9d, 8'h9d,
		8'h83, 8'h00, 8'ha3, 8'ha3, 8'h9b, 8'h9b, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'ha1, 8'ha1, 8'h00, 8'h00, 8'hb7, 8'hb7, 8'h00, 8'h00,
		8'h00, 8'h00};
	localparam lsb_t CONS_SG [NCONS] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'hb3, 8'hac, 8'h00, 8'h00, 8'h9f, 8'h00,
		8'h00, 8'h00, 8'ha6, 8'ha6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hb9, 8'hb9, 8'h82, 8'h9e,
		8'h00, 8'h00};
	localparam lsb_t CONS_KEY [NCONS] = '{
		8'h71, 8'h51, 8'h77, 8'h57, 8'h72, 8'h52, 8'h74, 8'h54, 8'h79, 8'h59,
		8'h70, 8'h50, 8'h73, 8'h53, 8'h64, 8'h44, 8'h66, 8'h46, 8'h67, 8'h47,
		8'h68, 8'h48, 8'h6a, 8'h4a, 8'h6b, 8'h4b, 8'h6c, 8'h4c, 8'h7a, 8'h5a,
		8'h78, 8'h58, 8'h63, 8'h43, 8'h76, 8'h56, 8'h62, 8'h42, 8'h6e, 8'h4e,
		8'h6d, 8'h4d};

	localparam lsb_t VOW_IND [NVOW] = '{
		8'h85, 8'h87, 8'h91, 8'h91, 8'h89, 8'h93, 8'h94, 8'h96, 8'h8b, 8'h8d};
	localparam lsb_t VOW_DIND [NVOW] = '{
		8'h86, 8'h88, 8'h92, 8'h92, 8'h8a, 8'h00, 8'h95, 8'h00, 8'h8c, 8'h8e};
	localparam lsb_t VOW_SIGN [NVOW] = '{
		8'hcf, 8'hd0, 8'hd9, 8'hd9, 8'hd2, 8'hdb, 8'hdc, 8'hde, 8'hd4, 8'hd8};
	localparam lsb_t VOW_DSIGN [NVOW] = '{
		8'hcf, 8'hd1, 8'hda, 8'hda, 8'hd3, 8'hdb, 8'hdd, 8'hdf, 8'hd6, 8'hf2};
	localparam lsb_t VOW_KEY [NVOW] = '{
		8'h61, 8'h41, 8'h65, 8'h45, 8'h69, 8'h49, 8'h6f, 8'h4f, 8'h75, 8'h55};

	// table code to code point
	function automatic cp_t code_of(input lsb_t l);
		cp_t r;
		if (l[7]) begin
			r = CP_SINH_PAGE | {8'h00, l};
		end else if (l == LSB_ZWNJ || l == LSB_ZWJ) begin
			r = CP_JOINER_BASE | {8'h00, l};
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage : sktr_pkg
`default_nettype wire

// ===== rtl/sinhala_key_transliterator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sinhala_key_transliterator
// turns keystrokes into Sinhala code points with context rules
// ----------------------------------------------------------------------------
// usage:
//   s channel: one beat per keystroke (key char, flags, character before cursor)
//   m channel: one to three beats per keystroke, tlast on the final beat of a key;
//     each beat carries handled, delete-previous, char-valid and a code point
//   path: a key passes the input beat register and the decoder, and its first beat shows from the result register
//   throughput: one output beat per cycle while m_tready is high, so a key takes 1 to 3 beats set by
//     the number of characters it emits through the beat sequencer
//   the next key is taken while the current result waits in the result register
//   reset: pipeline empty, Sinhala mode on
//   stall: with m_tready low the result holds and s_tready drops once the input
//     register is also occupied
//   the mode toggle takes effect for keys behind the toggle beat
// ----------------------------------------------------------------------------
module sinhala_key_transliterator import sktr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // key_char, key_is_plain, toggle_key, has_context, prev_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // handled, delete_previous, char_valid, out_char
	output logic             m_tlast
);

	key_t data_s1;
	logic valid_s1;
	logic mode_q;
	logic emit_ready;
	res_t dec_res;

	assign s_tready = !valid_s1 || emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= 1'b1;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (valid_s1 && emit_ready && data_s1.toggle_key) begin
				mode_q <= !mode_q;
			end
		end
	end

	// input beat register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata[34:0];
		end
	end

	sktr_decode u_decode (
		.key          (data_s1),
		.sinhala_mode (mode_q),
		.res          (dec_res)
	);

	sktr_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_ready (emit_ready),
		.in_res   (dec_res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule : sinhala_key_transliterator
`default_nettype wire

// ===== rtl/sktr_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktr_decode
// table lookups and context rules that turn one keystroke into a result
// ----------------------------------------------------------------------------
module sktr_decode import sktr_pkg::*; (
	input  wire key_t key,
	input  wire logic sinhala_mode,
	output res_t      res
);

	logic ctx_sinh, ctx_ok;
	lsb_t ctx_lsb;
	logic cons_hit, ctx_hit, vow_hit;
	lsb_t cons_chr, ctx_mp;
	lsb_t v_ind, v_dind, v_sign, v_dsign;

	// context character as table code
	assign ctx_sinh = key.prev_char[15:7] == SINH_BLOCK_HI;
	assign ctx_ok = key.has_context &&
		(ctx_sinh || key.prev_char == CP_ZWNJ || key.prev_char == CP_ZWJ);
	assign ctx_lsb = ctx_sinh ? {1'b1, key.prev_char[6:0]} : key.prev_char[7:0];

	// consonant by key, consonant by context code (first row wins)
	always_comb begin
		cons_hit = 1'b0;
		cons_chr = '0;
		ctx_hit  = 1'b0;
		ctx_mp   = '0;
		for (int i = NCONS - 1; i >= 0; i--) begin
			if (key.key_char == {8'h00, CONS_KEY[i]}) begin
				cons_hit = 1'b1;
				cons_chr = CONS_CHR[i];
			end
			if (ctx_ok && (CONS_CHR[i] == ctx_lsb || CONS_MP[i] == ctx_lsb ||
				CONS_SG[i] == ctx_lsb)) begin
				ctx_hit = 1'b1;
				ctx_mp  = CONS_MP[i];
			end
		end
	end

	// vowel by key
	always_comb begin
		vow_hit = 1'b0;
		v_ind   = '0;
		v_dind  = '0;
		v_sign  = '0;
		v_dsign = '0;
		for (int i = NVOW - 1; i >= 0; i--) begin
			if (key.key_char == {8'h00, VOW_KEY[i]}) begin
				vow_hit = 1'b1;
				v_ind   = VOW_IND[i];
				v_dind  = VOW_DIND[i];
				v_sign  = VOW_SIGN[i];
				v_dsign = VOW_DSIGN[i];
			end
		end
	end

	always_comb begin
		res = '0;
		if (key.toggle_key) begin
			res.handled = 1'b1;
		end else if (!sinhala_mode && key.key_is_plain) begin
			res.handled = 1'b1;
			res.cnt     = 2'd1;
			res.ch[0]   = key.key_char;
		end else if (cons_hit) begin
			res.handled = 1'b1;
			res.cnt     = 2'd1;
			res.ch[0]   = code_of(cons_chr);
			if (ctx_hit) begin
				if (key.key_char == KEY_LC_W) begin
					res.ch[0] = CP_HAL;
				end else if (key.key_char == KEY_UC_W) begin
					res.cnt   = 2'd2;
					res.ch[0] = CP_HAL;
					res.ch[1] = CP_ZWJ;
				end else if ((key.key_char == KEY_UC_H || key.key_char == KEY_UC_G) &&
					ctx_mp != '0) begin
					res.delete_previous = 1'b1;
					res.ch[0] = code_of(ctx_mp);
				end else if (key.key_char == KEY_UC_R) begin
					res.cnt   = 2'd3;
					res.ch[0] = CP_HAL;
					res.ch[1] = CP_ZWJ;
					res.ch[2] = CP_RA;
				end else if (key.key_char == KEY_UC_Y) begin
					res.cnt   = 2'd3;
					res.ch[0] = CP_HAL;
					res.ch[1] = CP_ZWJ;
					res.ch[2] = CP_YA;
				end
			end
		end else if (vow_hit) begin
			res.handled = 1'b1;
			res.cnt     = 2'd1;
			if (ctx_ok && ctx_lsb >= LSB_CONS_LO && ctx_lsb <= LSB_CONS_HI) begin
				res.ch[0] = code_of(v_sign);
			end else if (ctx_ok && ctx_lsb == v_ind) begin
				res.delete_previous = 1'b1;
				res.ch[0] = code_of(v_dind);
			end else if (ctx_ok && ctx_lsb == v_sign) begin
				res.delete_previous = 1'b1;
				res.ch[0] = code_of(v_dsign);
			end else begin
				res.ch[0] = code_of(v_ind);
			end
		end
	end

endmodule : sktr_decode
`default_nettype wire

// ===== rtl/sktr_emitter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktr_emitter
// result register and beat sequencer, one character beat per cycle while m_tready is high
// ----------------------------------------------------------------------------
module sktr_emitter import sktr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire res_t        in_res,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast
);

	res_t       res_q;
	logic       full_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       beat_last;
	logic       beat_del;
	logic       beat_cv;
	cp_t        beat_char;

	assign last_idx  = (res_q.cnt == 2'd0) ? 2'd0 : res_q.cnt - 2'd1;
	assign beat_last = idx_q == last_idx;
	assign in_ready  = !full_q || (m_tready && beat_last);

	assign beat_del  = res_q.delete_previous && (idx_q == 2'd0);
	assign beat_cv   = res_q.cnt != 2'd0;
	assign beat_char = beat_cv ? res_q.ch[idx_q] : '0;

	assign m_tvalid = full_q;
	assign m_tlast  = beat_last;
	assign m_tdata  = {5'b0, beat_char, beat_cv, beat_del, res_q.handled};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (in_valid && in_ready) begin
			full_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (full_q && m_tready) begin
			if (beat_last) begin
				full_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

	// beat index stays within the character count
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> idx_q <= last_idx)
		else $error("beat index beyond last character");

	// delete flag only on the first beat of a key
	a_del_first: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && idx_q != 2'd0) |-> !m_tdata[1])
		else $error("delete flag on a later beat");

	// an unhandled key is a single empty beat
	a_unhandled: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !m_tdata[0]) |-> (m_tlast && !m_tdata[2] && m_tdata[18:3] == '0))
		else $error("unhandled key with payload");

	// a later beat only follows a taken beat of the same key
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && m_tready && !beat_last) |=> (full_q && idx_q == $past(idx_q) + 2'd1))
		else $error("beat sequence skipped");

endmodule : sktr_emitter
`default_nettype wire

// ===== bench/sinhala_key_transliterator_test.sv =====
// ----------------------------------------------------------------------------
// sinhala_key_transliterator_test
// self-checking bench for the keystroke transliterator
// ----------------------------------------------------------------------------
// a scoreboard predicts the result beats of every accepted keystroke from its
// own copy of the key tables and the mode bit, and checks each output beat in
// order. a short directed run covers the context rules, then random keys run
// under three idle patterns and one long output hold.
// ----------------------------------------------------------------------------
module sinhala_key_transliterator_test;
	import sktr_pkg::*;

	localparam cp_t  SINH_FIRST = 16'h0d80;
	localparam cp_t  SINH_LAST  = 16'h0dff;
	localparam lsb_t LSB_SINH   = 8'h80;

	// {char, mahaprana, sagngnaka, key}
	localparam logic [31:0] CONS_TAB [NCONS] = '{
		32'ha4_00_00_71, 32'ha5_00_00_51, 32'hc0_00_00_77, 32'h0c_00_00_57,
		32'hbb_00_00_72, 32'hbb_00_00_52, 32'had_ae_00_74, 32'ha7_a8_00_54,
		32'hba_00_00_79, 32'hba_00_00_59, 32'hb4_b5_00_70, 32'hb5_b5_00_50,
		32'hc3_c2_00_73, 32'hc1_c2_00_53, 32'haf_b0_b3_64, 32'ha9_aa_ac_44,
		32'hc6_00_00_66, 32'hc6_00_00_46, 32'h9c_9d_9f_67, 32'h9f_9d_00_47,
		32'hc4_83_00_68, 32'hc4_00_00_48, 32'ha2_a3_a6_6a, 32'ha3_a3_a6_4a,
		32'h9a_9b_00_6b, 32'h9b_9b_00_4b, 32'hbd_00_00_6c, 32'hc5_00_00_4c,
		32'h8f_00_00_7a, 32'h90_00_00_5a, 32'h82_00_00_78, 32'h9e_00_00_58,
		32'ha0_a1_00_63, 32'ha1_a1_00_43, 32'hc0_00_00_76, 32'hc0_00_00_56,
		32'hb6_b7_b9_62, 32'hb7_b7_b9_42, 32'hb1_00_82_6e, 32'hab_00_9e_4e,
		32'hb8_00_00_6d, 32'hb9_00_00_4d};

	// {independent, doubled independent, sign, doubled sign, key}
	localparam logic [39:0] VOW_TAB [NVOW] = '{
		40'h85_86_cf_cf_61, 40'h87_88_d0_d1_41, 40'h91_92_d9_da_65,
		40'h91_92_d9_da_45, 40'h89_8a_d2_d3_69, 40'h93_00_db_db_49,
		40'h94_95_dc_dd_6f, 40'h96_00_de_df_4f, 40'h8b_8c_d4_d6_75,
		40'h8d_8e_d8_f2_55};

	typedef struct packed {
		logic handled;
		logic delete_previous;
		logic char_valid;
		cp_t  out_char;
		logic last;
	} beat_t;

	function automatic cp_t lsb_to_cp(input lsb_t l);
		if (l >= LSB_SINH)
			return CP_SINH_PAGE + cp_t'(l);
		if (l == LSB_ZWNJ || l == LSB_ZWJ)
			return CP_JOINER_BASE + cp_t'(l);
		return '0;
	endfunction

	class key_scoreboard;
		bit    sinhala_on;
		beat_t pending [$];
		int    keys;
		int    toggles;
		int    beats;
		int    mismatches;

		function new();
			sinhala_on = 1'b1;
		endfunction

		function void note_key(input key_t k);
			int    ctx;
			int    ci;
			int    vi;
			int    li;
			int    i;
			int    n;
			int    cnt;
			bit    hnd;
			bit    del;
			lsb_t  mp;
			cp_t   chars [3];
			beat_t b;
			keys++;
			ctx = -1;
			if (k.has_context) begin
				if (k.prev_char >= SINH_FIRST && k.prev_char <= SINH_LAST)
					ctx = int'(k.prev_char - CP_SINH_PAGE);
				else if (k.prev_char == CP_ZWNJ || k.prev_char == CP_ZWJ)
					ctx = int'(k.prev_char - CP_JOINER_BASE);
			end
			ci = -1;
			vi = -1;
			li = -1;
			for (i = NCONS - 1; i >= 0; i--) begin
				if (cp_t'(CONS_TAB[i][7:0]) == k.key_char)
					ci = i;
				if (ctx == int'(CONS_TAB[i][31:24]) || ctx == int'(CONS_TAB[i][23:16]) ||
						ctx == int'(CONS_TAB[i][15:8]))
					li = i;
			end
			for (i = NVOW - 1; i >= 0; i--)
				if (cp_t'(VOW_TAB[i][7:0]) == k.key_char)
					vi = i;
			hnd = 1'b1;
			del = 1'b0;
			n = 0;
			chars[0] = '0;
			chars[1] = '0;
			chars[2] = '0;
			if (k.toggle_key) begin
				sinhala_on = !sinhala_on;
				toggles++;
			end else if (!sinhala_on && k.key_is_plain) begin
				chars[0] = k.key_char;
				n = 1;
			end else if (ci >= 0) begin
				chars[0] = CP_HAL;
				chars[1] = CP_ZWJ;
				mp = (li >= 0) ? CONS_TAB[li][23:16] : '0;
				if (li >= 0 && k.key_char == KEY_LC_W) begin
					n = 1;
				end else if (li >= 0 && k.key_char == KEY_UC_W) begin
					n = 2;
				end else if (li >= 0 && (k.key_char == KEY_UC_H || k.key_char == KEY_UC_G) &&
						mp != 0) begin
					chars[0] = lsb_to_cp(mp);
					del = 1'b1;
					n = 1;
				end else if (li >= 0 && k.key_char == KEY_UC_R) begin
					chars[2] = CP_RA;
					n = 3;
				end else if (li >= 0 && k.key_char == KEY_UC_Y) begin
					chars[2] = CP_YA;
					n = 3;
				end else begin
					chars[0] = lsb_to_cp(CONS_TAB[ci][31:24]);
					n = 1;
				end
			end else if (vi >= 0) begin
				n = 1;
				if (ctx >= int'(LSB_CONS_LO) && ctx <= int'(LSB_CONS_HI)) begin
					chars[0] = lsb_to_cp(VOW_TAB[vi][23:16]);
				end else if (ctx == int'(VOW_TAB[vi][39:32])) begin
					chars[0] = lsb_to_cp(VOW_TAB[vi][31:24]);
					del = 1'b1;
				end else if (ctx == int'(VOW_TAB[vi][23:16])) begin
					chars[0] = lsb_to_cp(VOW_TAB[vi][15:8]);
					del = 1'b1;
				end else begin
					chars[0] = lsb_to_cp(VOW_TAB[vi][39:32]);
				end
			end else begin
				hnd = 1'b0;
			end
			cnt = (n > 0) ? n : 1;
			for (i = 0; i < cnt; i++) begin
				b.handled         = hnd;
				b.delete_previous = (i == 0) && del;
				b.char_valid      = (n > 0);
				b.out_char        = (n > 0) ? chars[i] : '0;
				b.last            = (i == cnt - 1);
				pending.push_back(b);
			end
		endfunction

		function void check_beat(input logic [23:0] d, input logic l);
			beat_t want;
			beat_t got;
			got.handled         = d[0];
			got.delete_previous = d[1];
			got.char_valid      = d[2];
			got.out_char        = d[18:3];
			got.last            = l;
			beats++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: tdata %h tlast %b", d, l);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"beat %0d: expected handled %b del %b valid %b char %h last %b,",
						" got handled %b del %b valid %b char %h last %b"}, beats,
						want.handled, want.delete_previous, want.char_valid, want.out_char,
						want.last, got.handled, got.delete_previous, got.char_valid,
						got.out_char, got.last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	int          s_idle_pct = 0;
	int          r_idle_pct = 0;
	logic        hold_go = 1'b0;
	logic        hold_on = 1'b0;

	key_scoreboard board;

	sinhala_key_transliterator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic key_t mk(input cp_t key, input logic plain, input logic tog,
			input logic ctx, input cp_t prev);
		key_t k;
		k.key_char     = key;
		k.key_is_plain = plain;
		k.toggle_key   = tog;
		k.has_context  = ctx;
		k.prev_char    = prev;
		return k;
	endfunction

	task automatic send_key(input key_t k);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, k};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_key(k);
	endtask

	task automatic send_random_keys(input int count);
		key_t k;
		int   pick;
		int   idx;
		int   col;
		lsb_t code;
		repeat (count) begin
			k = '0;
			k.toggle_key   = board.sinhala_on ? ($urandom_range(99) < 4) : ($urandom_range(99) < 30);
			k.key_is_plain = $urandom_range(99) < 80;
			k.has_context  = $urandom_range(99) < 80;
			pick = $urandom_range(99);
			if (pick < 40)
				k.key_char = cp_t'(CONS_TAB[$urandom_range(NCONS - 1)][7:0]);
			else if (pick < 65)
				k.key_char = cp_t'(VOW_TAB[$urandom_range(NVOW - 1)][7:0]);
			else if (pick < 80)
				k.key_char = cp_t'($urandom_range(127));
			else
				k.key_char = cp_t'($urandom);
			pick = $urandom_range(99);
			if (pick < 35) begin
				idx  = $urandom_range(NCONS - 1);
				col  = $urandom_range(2);
				code = CONS_TAB[idx][31 - 8 * col -: 8];
				if (code == 0)
					code = CONS_TAB[idx][31:24];
				k.prev_char = lsb_to_cp(code);
			end else if (pick < 55) begin
				idx  = $urandom_range(NVOW - 1);
				col  = $urandom_range(3);
				code = VOW_TAB[idx][39 - 8 * col -: 8];
				k.prev_char = lsb_to_cp(code);
			end else if (pick < 65) begin
				k.prev_char = $urandom_range(1) ? CP_ZWJ : CP_ZWNJ;
			end else if (pick < 75) begin
				k.prev_char = SINH_FIRST + cp_t'($urandom_range(127));
			end else if (pick < 85) begin
				k.prev_char = CP_HAL;
			end else begin
				k.prev_char = cp_t'($urandom);
			end
			send_key(k);
		end
	endtask

	// result side: check each beat, then choose ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_beat(m_tdata, m_tlast);
		if (!arst_n || hold_on)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(99) >= r_idle_pct;
	end

	// long output hold so the block backs up into its input
	initial begin
		while (!hold_go)
			@(posedge clk);
		hold_on <= 1'b1;
		repeat (90) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#800000;
		$display("sinhala_key_transliterator verification failed");
		$finish;
	end

	initial begin
		board = new();
		s_idle_pct = 38;
		r_idle_pct <= 66;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_key(mk(16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000));
		send_key(mk(16'hffff, 1'b0, 1'b0, 1'b1, 16'hffff));
		send_key(mk(cp_t'("k"), 1'b1, 1'b0, 1'b0, 16'h0000));
		// consonant context: hal, hal + zwj, mahaprana, rakaransaya, yansaya
		send_key(mk(cp_t'("w"), 1'b1, 1'b0, 1'b1, 16'h0d9a));
		send_key(mk(cp_t'("W"), 1'b1, 1'b0, 1'b1, 16'h0dad));
		send_key(mk(cp_t'("H"), 1'b1, 1'b0, 1'b1, 16'h0dad));
		send_key(mk(cp_t'("G"), 1'b1, 1'b0, 1'b1, 16'h0d9c));
		send_key(mk(cp_t'("H"), 1'b1, 1'b0, 1'b1, 16'h0dc0));
		send_key(mk(cp_t'("R"), 1'b1, 1'b0, 1'b1, 16'h0db4));
		send_key(mk(cp_t'("Y"), 1'b0, 1'b0, 1'b1, 16'h0db5));
		send_key(mk(cp_t'("W"), 1'b1, 1'b0, 1'b0, 16'h0dad));
		// joiners before the cursor
		send_key(mk(cp_t'("k"), 1'b1, 1'b0, 1'b1, CP_ZWNJ));
		send_key(mk(cp_t'("W"), 1'b1, 1'b0, 1'b1, CP_ZWNJ));
		send_key(mk(cp_t'("a"), 1'b1, 1'b0, 1'b1, CP_ZWJ));
		// vowel signs, doubled vowels, empty doubled entry, range edges
		send_key(mk(cp_t'("a"), 1'b1, 1'b0, 1'b1, 16'h0d9a));
		send_key(mk(cp_t'("a"), 1'b1, 1'b0, 1'b1, 16'h0d85));
		send_key(mk(cp_t'("I"), 1'b1, 1'b0, 1'b1, 16'h0d93));
		send_key(mk(cp_t'("o"), 1'b1, 1'b0, 1'b1, 16'h0ddc));
		send_key(mk(cp_t'("U"), 1'b1, 1'b0, 1'b1, 16'h0dc6));
		send_key(mk(cp_t'("U"), 1'b1, 1'b0, 1'b1, 16'h0dc7));
		// latin mode
		send_key(mk(cp_t'("1"), 1'b1, 1'b1, 1'b0, 16'h0000));
		send_key(mk(cp_t'("x"), 1'b1, 1'b0, 1'b1, 16'h0d9a));
		send_key(mk(cp_t'("a"), 1'b0, 1'b0, 1'b0, 16'h0000));
		send_key(mk(16'h0d85, 1'b0, 1'b0, 1'b0, 16'h0000));
		send_key(mk(16'h0000, 1'b0, 1'b1, 1'b1, 16'hffff));

		send_random_keys(110);
		s_idle_pct = 66;
		r_idle_pct <= 38;
		send_random_keys(110);
		s_idle_pct = 0;
		r_idle_pct <= 0;
		hold_go <= 1'b1;
		send_random_keys(115);
		s_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("run covered %0d keystrokes with %0d mode toggles, %0d result beats checked",
			board.keys, board.toggles, board.beats);
		$display("idle patterns on both sides plus one long output hold; %0d mismatches",
			board.mismatches);
		if (board.mismatches == 0)
			$display("sinhala_key_transliterator verification clean");
		else
			$display("sinhala_key_transliterator verification failed");
		$finish;
	end

endmodule
